// ===== hw/rtl/tof_slew_correction_core_assert.svh =====
// Assertion macros for the slew correction core.
`ifndef TOF_SLEW_CORRECTION_CORE_ASSERT_SVH
`define TOF_SLEW_CORRECTION_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TSC_ASSERT(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
		else $error("tof slew correction: assertion failed");
`define TSC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("tof slew correction: assertion failed");
`else
`define TSC_ASSERT(lbl, ck, rn, prop)
`define TSC_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

// ===== hw/rtl/tsc_pkg.sv =====
// Types, widths, constants and the tanh table of the slew correction core.
package tsc_pkg;

	localparam int TIME_W     = 24;
	localparam int CHARGE_W   = 12;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 2;

	localparam int TANH_TABLE_ENTRIES = 256;
	localparam int TANH_IDX_W = $clog2(TANH_TABLE_ENTRIES + 1);

	// argument x = |gain|*q/500, Q.12, rounded half up
	localparam int MAG_W       = CFG_W;
	localparam int PROD_W      = MAG_W + CHARGE_W;
	localparam int ARG_ROUND   = 250;
	localparam int QUO_IN_W    = PROD_W - 2;
	// floor(y/125) = (y * RECIP_MUL) >> RECIP_SHIFT for y < 2^25
	localparam int RECIP_MUL   = 34359739;
	localparam int RECIP_SHIFT = 32;
	localparam int RECIP_W     = 26;
	localparam int QUO_PROD_W  = QUO_IN_W + RECIP_W;
	localparam int AX_W        = 19;

	localparam int X_FRAC_W = 14;
	localparam int X_LIMIT  = 1 << X_FRAC_W;
	localparam int P_W      = X_FRAC_W + TANH_IDX_W;

	localparam int TANH_W    = 17;
	localparam int TANH_ONE  = 65536;
	localparam int ONEM_W    = TANH_W + 1;
	localparam int INTERP_W  = TANH_W + X_FRAC_W;
	localparam int TERM_W    = CFG_W + ONEM_W + 1;

	localparam int SUM_W   = 42;
	localparam int ROUND_W = 16;
	localparam int RES_W   = SUM_W - ROUND_W;

	localparam logic signed [TIME_W-1:0] TIME_MAX = {1'b0, {(TIME_W-1){1'b1}}};
	localparam logic signed [TIME_W-1:0] TIME_MIN = {1'b1, {(TIME_W-1){1'b0}}};

	localparam longint Q30_ONE = longint'(1) << 30;
	// series terms stay within 2^30 in magnitude
	localparam int SERIES_Q_W = 31;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRONT_AMPLITUDE = 2'd0,
		REG_FRONT_GAIN      = 2'd1,
		REG_BACK_AMPLITUDE  = 2'd2,
		REG_BACK_GAIN       = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [CFG_W-1:0] amplitude;
		logic signed [CFG_W-1:0] gain;
	} side_cfg_t;

	typedef logic [TANH_W-1:0] tanh_tab_t [0:TANH_TABLE_ENTRIES];

	// signed division truncated toward zero, shift and subtract; |quotient| < 2^qbits
	function automatic longint div_trunc(input longint num, input longint den, input int qbits);
		logic [63:0] n_mag;
		logic [63:0] d_mag;
		logic [63:0] quo;
		n_mag = (num < 0) ? 64'(-num) : 64'(num);
		d_mag = (den < 0) ? 64'(-den) : 64'(den);
		quo = '0;
		for (int b = qbits - 1; b >= 0; b--) begin
			if (n_mag >= (d_mag << b)) begin
				n_mag = n_mag - (d_mag << b);
				quo[b] = 1'b1;
			end
		end
		return ((num < 0) != (den < 0)) ? -longint'(quo) : longint'(quo);
	endfunction

	// tanh(4k/N) in Q.16 from e^(-8k/N): Taylor series in Q.30, then squared three times
	function automatic tanh_tab_t build_tanh_tab();
		tanh_tab_t tab;
		longint g;
		longint e;
		longint term;
		longint sum;
		for (int k = 0; k <= TANH_TABLE_ENTRIES; k++) begin
			g = (longint'(k) * Q30_ONE) / TANH_TABLE_ENTRIES;
			sum = Q30_ONE;
			term = Q30_ONE;
			for (int i = 1; i <= 20; i++) begin
				term = (-(term * g)) / Q30_ONE;
				term = div_trunc(term, longint'(i), SERIES_Q_W);
				sum = sum + term;
			end
			e = sum;
			if (e < 0) begin
				e = 0;
			end
			for (int j = 0; j < 3; j++) begin
				e = (e * e + (longint'(1) << 29)) / Q30_ONE;
				if (e < 0) begin
					e = 0;
				end
			end
			tab[k] = TANH_W'(div_trunc((Q30_ONE - e) * TANH_ONE + (Q30_ONE + e) / 2,
				Q30_ONE + e, TANH_W));
		end
		return tab;
	endfunction

	localparam tanh_tab_t TANH_TAB = build_tanh_tab();

endpackage

// ===== hw/rtl/tsc_slew_term.sv =====
// One side's slew term: amplitude * (1 - tanh(gain*q/500)), five pipeline stages.
module tsc_slew_term (
	input  logic                                clk,
	input  logic                                en,
	input  tsc_pkg::side_cfg_t                  cfg,
	input  logic [tsc_pkg::CHARGE_W-1:0]        charge,
	output logic signed [tsc_pkg::TERM_W-1:0]   term
);

	logic [tsc_pkg::MAG_W-1:0]       mag;
	logic [tsc_pkg::PROD_W-1:0]      x_s1;
	logic                            neg_s1;
	logic [tsc_pkg::QUO_PROD_W-1:0]  quo_prod;
	logic [tsc_pkg::AX_W-1:0]        ax_s2;
	logic                            neg_s2;
	logic [tsc_pkg::P_W-1:0]         p;
	logic [tsc_pkg::TANH_IDX_W-1:0]  idx;
	logic [tsc_pkg::TANH_IDX_W-1:0]  idx_next;
	logic [tsc_pkg::TANH_W-1:0]      lo_s3;
	logic [tsc_pkg::TANH_W-1:0]      hi_s3;
	logic [tsc_pkg::X_FRAC_W-1:0]    frac_s3;
	logic                            big_s3;
	logic                            neg_s3;
	logic [tsc_pkg::TANH_W-1:0]      diff;
	logic [tsc_pkg::INTERP_W-1:0]    interp;
	logic [tsc_pkg::TANH_W-1:0]      tanh_mag;
	logic [tsc_pkg::ONEM_W-1:0]      onem_s4;
	logic signed [tsc_pkg::TERM_W-1:0] term_s5;

	assign mag = cfg.gain[tsc_pkg::CFG_W-1] ? tsc_pkg::MAG_W'(-cfg.gain)
		: tsc_pkg::MAG_W'(cfg.gain);

	assign quo_prod = tsc_pkg::QUO_PROD_W'(x_s1[tsc_pkg::PROD_W-1:2])
		* tsc_pkg::QUO_PROD_W'(tsc_pkg::RECIP_MUL);

	// ax below the limit here whenever the table value is used
	assign p = tsc_pkg::P_W'(ax_s2[tsc_pkg::X_FRAC_W-1:0])
		* tsc_pkg::P_W'(tsc_pkg::TANH_TABLE_ENTRIES);
	assign idx      = p[tsc_pkg::X_FRAC_W +: tsc_pkg::TANH_IDX_W];
	assign idx_next = idx + tsc_pkg::TANH_IDX_W'(1);

	assign diff     = hi_s3 - lo_s3;
	assign interp   = tsc_pkg::INTERP_W'(diff) * tsc_pkg::INTERP_W'(frac_s3);
	assign tanh_mag = big_s3 ? tsc_pkg::TANH_W'(tsc_pkg::TANH_ONE)
		: lo_s3 + interp[tsc_pkg::INTERP_W-1:tsc_pkg::X_FRAC_W];

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= tsc_pkg::PROD_W'(mag) * tsc_pkg::PROD_W'(charge)
				+ tsc_pkg::PROD_W'(tsc_pkg::ARG_ROUND);
			neg_s1  <= cfg.gain[tsc_pkg::CFG_W-1];

			ax_s2   <= quo_prod[tsc_pkg::RECIP_SHIFT +: tsc_pkg::AX_W];
			neg_s2  <= neg_s1;

			big_s3  <= ax_s2 >= tsc_pkg::AX_W'(tsc_pkg::X_LIMIT);
			lo_s3   <= tsc_pkg::TANH_TAB[idx];
			hi_s3   <= tsc_pkg::TANH_TAB[idx_next];
			frac_s3 <= p[tsc_pkg::X_FRAC_W-1:0];
			neg_s3  <= neg_s2;

			onem_s4 <= neg_s3
				? tsc_pkg::ONEM_W'(tsc_pkg::TANH_ONE) + tsc_pkg::ONEM_W'(tanh_mag)
				: tsc_pkg::ONEM_W'(tsc_pkg::TANH_ONE) - tsc_pkg::ONEM_W'(tanh_mag);

			term_s5 <= tsc_pkg::TERM_W'(cfg.amplitude)
				* tsc_pkg::TERM_W'(signed'({1'b0, onem_s4}));
		end
	end

	assign term = term_s5;

endmodule

// ===== hw/rtl/tof_slew_correction_core.sv =====
// Top level of the time-of-flight slew correction core.
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_ready   time_in, charge_front, charge_back, charge_valid
//  out      output     out_valid / out_ready time_out, saturated
//  cfg      input      cfg_we                cfg_index, cfg_data
//
// One item per cycle while the result is not stalled, through the six pipeline
// stages (argument multiply, divide by 500, table read, interpolation,
// amplitude multiply, sum and clip). Items with charge_valid low are taken and
// give no result. A stalled result freezes the whole pipeline. Reset clears
// the configuration registers and the stage valid bits; no clearing pass is needed.
`include "tof_slew_correction_core_assert.svh"

module tof_slew_correction_core (
	input  logic                                 clk,
	input  logic                                 arst_n,

	input  logic                                 cfg_we,
	input  logic [tsc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [tsc_pkg::CFG_W-1:0]            cfg_data,

	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [tsc_pkg::TIME_W-1:0]    time_in,
	input  logic [tsc_pkg::CHARGE_W-1:0]         charge_front,
	input  logic [tsc_pkg::CHARGE_W-1:0]         charge_back,
	input  logic                                 charge_valid,

	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [tsc_pkg::TIME_W-1:0]    time_out,
	output logic                                 saturated
);

	tsc_pkg::side_cfg_t front_cfg_q;
	tsc_pkg::side_cfg_t back_cfg_q;

	logic en;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic [5:0] stage_valid;

	logic signed [tsc_pkg::TIME_W-1:0] time_s1, time_s2, time_s3, time_s4, time_s5;
	logic signed [tsc_pkg::TERM_W-1:0] front_term;
	logic signed [tsc_pkg::TERM_W-1:0] back_term;

	logic signed [tsc_pkg::SUM_W-1:0]  sum;
	logic signed [tsc_pkg::RES_W-1:0]  res;
	logic signed [tsc_pkg::TIME_W-1:0] time_s6;
	logic                              sat_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_cfg_q <= '0;
			back_cfg_q  <= '0;
		end else if (cfg_we) begin
			unique case (tsc_pkg::cfg_reg_t'(cfg_index))
				tsc_pkg::REG_FRONT_AMPLITUDE: front_cfg_q.amplitude <= cfg_data;
				tsc_pkg::REG_FRONT_GAIN:      front_cfg_q.gain      <= cfg_data;
				tsc_pkg::REG_BACK_AMPLITUDE:  back_cfg_q.amplitude  <= cfg_data;
				tsc_pkg::REG_BACK_GAIN:       back_cfg_q.gain       <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en       = out_ready || !valid_s6;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid && charge_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	assign stage_valid = {valid_s6, valid_s5, valid_s4, valid_s3, valid_s2, valid_s1};

	tsc_slew_term u_front (
		.clk    (clk),
		.en     (en),
		.cfg    (front_cfg_q),
		.charge (charge_front),
		.term   (front_term)
	);

	tsc_slew_term u_back (
		.clk    (clk),
		.en     (en),
		.cfg    (back_cfg_q),
		.charge (charge_back),
		.term   (back_term)
	);

	// round half up, floor via arithmetic shift
	assign sum = (tsc_pkg::SUM_W'(time_s5) <<< tsc_pkg::ROUND_W)
		- tsc_pkg::SUM_W'(front_term) - tsc_pkg::SUM_W'(back_term)
		+ tsc_pkg::SUM_W'(1 << (tsc_pkg::ROUND_W - 1));
	assign res = sum[tsc_pkg::SUM_W-1:tsc_pkg::ROUND_W];

	always_ff @(posedge clk) begin
		if (en) begin
			time_s1 <= time_in;
			time_s2 <= time_s1;
			time_s3 <= time_s2;
			time_s4 <= time_s3;
			time_s5 <= time_s4;
			if (res > tsc_pkg::RES_W'(tsc_pkg::TIME_MAX)) begin
				time_s6 <= tsc_pkg::TIME_MAX;
				sat_s6  <= 1'b1;
			end else if (res < tsc_pkg::RES_W'(tsc_pkg::TIME_MIN)) begin
				time_s6 <= tsc_pkg::TIME_MIN;
				sat_s6  <= 1'b1;
			end else begin
				time_s6 <= res[tsc_pkg::TIME_W-1:0];
				sat_s6  <= 1'b0;
			end
		end
	end

	assign out_valid = valid_s6;
	assign time_out  = time_s6;
	assign saturated = sat_s6;

	`TSC_ASSERT(a_sat_clipped, clk, arst_n, out_valid && saturated |-> (time_out == tsc_pkg::TIME_MAX || time_out == tsc_pkg::TIME_MIN))
	`TSC_ASSERT_NEXT(a_entry_valid, clk, arst_n, arst_n && in_ready, valid_s1 == $past(in_valid && charge_valid))
	`TSC_ASSERT_NEXT(a_stall_freeze, clk, arst_n, arst_n && !in_ready, $stable(stage_valid))

endmodule

// ===== test/tb_tof_slew_correction_core.sv =====
// Self-checking testbench of the slew correction core: directed table, then random phases.
`timescale 1ns / 1ps

module tb_tof_slew_correction_core;
	import tsc_pkg::*;

	localparam int LUT_N       = TANH_TABLE_ENTRIES;
	localparam int MAX_WAIT    = 11;
	localparam int FLUSH_WAIT  = 12;
	localparam int CYCLE_LIMIT = 500000;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 170;

	typedef struct packed {
		logic signed [TIME_W-1:0] time_out;
		logic                     saturated;
	} slew_result_t;

	typedef struct packed {
		side_cfg_t front;
		side_cfg_t back;
	} slew_cfg_t;

	typedef struct {
		int                       cfg_sel;
		logic signed [TIME_W-1:0] tin;
		logic [CHARGE_W-1:0]      qf;
		logic [CHARGE_W-1:0]      qb;
		logic                     cv;
		bit                       known;
		logic signed [TIME_W-1:0] exp_time;
		logic                     exp_sat;
	} dir_row_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_W-1:0]           cfg_data;
	logic                       in_valid;
	logic                       in_ready;
	logic signed [TIME_W-1:0]   time_in;
	logic [CHARGE_W-1:0]        charge_front;
	logic [CHARGE_W-1:0]        charge_back;
	logic                       charge_valid;
	logic                       out_valid;
	logic                       out_ready;
	logic signed [TIME_W-1:0]   time_out;
	logic                       saturated;

	longint                     tanh_lut [0:LUT_N];
	logic signed [CFG_W-1:0]    reg_shadow [4];
	slew_result_t               pending_results [$];
	slew_cfg_t                  dir_cfg [6];
	dir_row_t                   dir_rows [22];
	int                         err_count = 0;
	int                         cycle_count = 0;
	bit                         tx_busy = 0;
	bit                         rx_busy = 0;

	tof_slew_correction_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.time_in      (time_in),
		.charge_front (charge_front),
		.charge_back  (charge_back),
		.charge_valid (charge_valid),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.time_out     (time_out),
		.saturated    (saturated)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// tanh(4k/N) in Q.16, from e^(-8k/N) by series in Q.30 and three squarings
	function automatic void build_tanh_lut();
		longint step;
		longint ex;
		longint part;
		longint acc;
		for (int k = 0; k <= LUT_N; k++) begin
			step = (longint'(k) << 30) / LUT_N;
			acc  = Q30_ONE;
			part = Q30_ONE;
			for (int n = 1; n <= 20; n++) begin
				part = (-(part * step)) / Q30_ONE;
				part = part / n;
				acc  = acc + part;
			end
			ex = (acc < 0) ? 0 : acc;
			repeat (3) begin
				ex = (ex * ex + (longint'(1) << 29)) / Q30_ONE;
				if (ex < 0) ex = 0;
			end
			tanh_lut[k] = ((Q30_ONE - ex) * 65536 + (Q30_ONE + ex) / 2) / (Q30_ONE + ex);
		end
	endfunction

	// signed tanh(gain*q/500) in Q.16
	function automatic longint slew_tanh(input logic signed [CFG_W-1:0] gain,
			input logic [CHARGE_W-1:0] q);
		longint mag;
		longint ax;
		longint pos;
		longint seg;
		longint frac;
		longint val;
		mag = (gain < 0) ? -longint'(gain) : longint'(gain);
		ax  = (mag * longint'({1'b0, q}) + 250) / 500;
		if (ax >= X_LIMIT) begin
			val = 65536;
		end else begin
			pos  = ax * LUT_N;
			seg  = pos >> X_FRAC_W;
			frac = pos & (X_LIMIT - 1);
			if (seg > LUT_N - 1) seg = LUT_N - 1;
			val = tanh_lut[seg] + ((tanh_lut[seg+1] - tanh_lut[seg]) * frac) / X_LIMIT;
		end
		return (gain < 0) ? -val : val;
	endfunction

	function automatic bit predict_corrected_time(input logic signed [TIME_W-1:0] tin,
			input logic [CHARGE_W-1:0] qf, input logic [CHARGE_W-1:0] qb, input logic cv,
			output slew_result_t res);
		longint acc;
		longint rnd;
		res = '0;
		if (!cv) return 0;
		acc = longint'(tin) * 65536
			- longint'(reg_shadow[REG_FRONT_AMPLITUDE])
				* (65536 - slew_tanh(reg_shadow[REG_FRONT_GAIN], qf))
			- longint'(reg_shadow[REG_BACK_AMPLITUDE])
				* (65536 - slew_tanh(reg_shadow[REG_BACK_GAIN], qb));
		rnd = (acc + 32768) >>> 16;
		if (rnd > longint'(TIME_MAX)) begin
			res.time_out  = TIME_MAX;
			res.saturated = 1'b1;
		end else if (rnd < longint'(TIME_MIN)) begin
			res.time_out  = TIME_MIN;
			res.saturated = 1'b1;
		end else begin
			res.time_out  = TIME_W'(rnd);
			res.saturated = 1'b0;
		end
		return 1;
	endfunction

	function automatic logic [CFG_W-1:0] rand_reg_value(input bit is_gain);
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return CFG_W'($urandom);
			default: begin
				if (is_gain) return CFG_W'($urandom_range(0, 4000)) - 16'd2000;
				return CFG_W'($urandom_range(0, 8191)) - 16'd4096;
			end
		endcase
	endfunction

	// called at a falling edge, drops in_valid and waits for all pending results
	task automatic wait_drained();
		in_valid = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (FLUSH_WAIT) @(negedge clk);
	endtask

	task automatic apply_config(input slew_cfg_t c);
		logic [CFG_W-1:0] vals [4];
		cfg_reg_t idx;
		vals[REG_FRONT_AMPLITUDE] = c.front.amplitude;
		vals[REG_FRONT_GAIN]      = c.front.gain;
		vals[REG_BACK_AMPLITUDE]  = c.back.amplitude;
		vals[REG_BACK_GAIN]       = c.back.gain;
		idx = idx.first();
		forever begin
			cfg_we    = 1'b1;
			cfg_index = idx;
			cfg_data  = vals[idx];
			@(negedge clk);
			reg_shadow[idx] = vals[idx];
			if (idx == idx.last()) break;
			idx = idx.next();
		end
		cfg_we = 1'b0;
	endtask

	// called at a falling edge, returns at a falling edge
	task automatic send_item(input logic signed [TIME_W-1:0] tin, input logic [CHARGE_W-1:0] qf,
			input logic [CHARGE_W-1:0] qb, input logic cv, input bit known,
			input slew_result_t typed);
		int gap;
		slew_result_t res;
		gap = tx_busy ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		time_in      = tin;
		charge_front = qf;
		charge_back  = qb;
		charge_valid = cv;
		in_valid     = 1'b1;
		do @(posedge clk); while (!in_ready);
		if (known) begin
			pending_results.push_back(typed);
		end else if (predict_corrected_time(tin, qf, qb, cv, res)) begin
			pending_results.push_back(res);
		end
		@(negedge clk);
	endtask

	// result side
	initial begin
		int stall;
		slew_result_t want;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = rx_busy ? 0 : $urandom_range(0, MAX_WAIT);
			if (stall > 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			if (pending_results.size() == 0) begin
				err_count++;
				if (err_count <= 10)
					$display("unexpected item: time_out=%0d saturated=%0b", time_out, saturated);
			end else begin
				want = pending_results.pop_front();
				if (time_out !== want.time_out || saturated !== want.saturated) begin
					err_count++;
					if (err_count <= 10)
						$display("mismatch: expected time_out=%0d saturated=%0b, got %0d %0b",
							want.time_out, want.saturated, time_out, saturated);
				end
			end
			@(negedge clk);
		end
	end

	// stimulus
	initial begin
		int cur_sel;
		int n_valid;
		slew_cfg_t rc;
		slew_result_t typed;
		logic signed [TIME_W-1:0] tin;
		logic [CHARGE_W-1:0] qv [2];
		logic cv;

		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		time_in      = '0;
		charge_front = '0;
		charge_back  = '0;
		charge_valid = 1'b0;
		for (int i = 0; i < 4; i++) reg_shadow[i] = '0;
		build_tanh_lut();

		dir_cfg[0] = '{'{16'sd0, 16'sd0}, '{16'sd0, 16'sd0}};
		dir_cfg[1] = '{'{-16'sd32768, 16'sd0}, '{16'sd0, 16'sd0}};
		dir_cfg[2] = '{'{16'sd32767, 16'sd0}, '{16'sd32767, 16'sd0}};
		dir_cfg[3] = '{'{-16'sd32768, -16'sd32768}, '{-16'sd32768, -16'sd32768}};
		dir_cfg[4] = '{'{16'sd32767, 16'sd32767}, '{16'sd32767, 16'sd32767}};
		dir_cfg[5] = '{'{16'sd1000, 16'sd4096}, '{-16'sd1000, -16'sd4096}};

		dir_rows = '{
			'{0, 24'sd0,       12'd0,    12'd0,    1'b1, 1, 24'sd0,       1'b0},
			'{0, TIME_MAX,     12'd4095, 12'd4095, 1'b1, 1, TIME_MAX,     1'b0},
			'{0, TIME_MIN,     12'd0,    12'd4095, 1'b1, 1, TIME_MIN,     1'b0},
			'{0, 24'sd123,     12'd7,    12'd9,    1'b0, 0, 24'sd0,       1'b0},
			'{0, -24'sd1,      12'd4095, 12'd0,    1'b1, 1, -24'sd1,      1'b0},
			// amplitude extremes with zero gain
			'{1, TIME_MAX,     12'd0,    12'd0,    1'b1, 1, TIME_MAX,     1'b1},
			'{1, 24'sd0,       12'd0,    12'd0,    1'b1, 1, 24'sd32768,   1'b0},
			'{1, TIME_MIN,     12'd4095, 12'd4095, 1'b1, 1, -24'sd8355840, 1'b0},
			'{2, TIME_MIN,     12'd0,    12'd0,    1'b1, 1, TIME_MIN,     1'b1},
			'{2, 24'sd0,       12'd2000, 12'd3000, 1'b1, 1, -24'sd65534,  1'b0},
			// full negative settings, tanh at -1 for nonzero charge
			'{3, TIME_MAX,     12'd4095, 12'd4095, 1'b1, 1, TIME_MAX,     1'b1},
			'{3, 24'sd0,       12'd4095, 12'd4095, 1'b1, 1, 24'sd131072,  1'b0},
			'{3, 24'sd0,       12'd0,    12'd0,    1'b1, 1, 24'sd65536,   1'b0},
			'{3, 24'sd55,      12'd4095, 12'd0,    1'b0, 0, 24'sd0,       1'b0},
			// full positive settings, tanh at +1 for nonzero charge
			'{4, TIME_MIN,     12'd4095, 12'd4095, 1'b1, 1, TIME_MIN,     1'b0},
			'{4, 24'sd12345,   12'd0,    12'd0,    1'b1, 1, -24'sd53189,  1'b0},
			'{4, 24'sd0,       12'd1,    12'd100,  1'b1, 0, 24'sd0,       1'b0},
			'{4, -24'sd300000, 12'd2047, 12'd4095, 1'b1, 0, 24'sd0,       1'b0},
			// interpolation range and the table limit
			'{5, 24'sd0,       12'd500,  12'd1000, 1'b1, 0, 24'sd0,       1'b0},
			'{5, 24'sd1000,    12'd2000, 12'd250,  1'b1, 0, 24'sd0,       1'b0},
			'{5, -24'sd1000,   12'd1,    12'd4095, 1'b1, 0, 24'sd0,       1'b0},
			'{5, 24'sd0,       12'd3000, 12'd2,    1'b1, 0, 24'sd0,       1'b0}
		};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		cur_sel = 0;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].cfg_sel != cur_sel) begin
				wait_drained();
				cur_sel = dir_rows[i].cfg_sel;
				apply_config(dir_cfg[cur_sel]);
			end
			typed.time_out  = dir_rows[i].exp_time;
			typed.saturated = dir_rows[i].exp_sat;
			send_item(dir_rows[i].tin, dir_rows[i].qf, dir_rows[i].qb, dir_rows[i].cv,
				dir_rows[i].known, typed);
		end

		typed = '0;
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			rc.front.amplitude = rand_reg_value(0);
			rc.front.gain      = rand_reg_value(1);
			rc.back.amplitude  = rand_reg_value(0);
			rc.back.gain       = rand_reg_value(1);
			apply_config(rc);
			tx_busy = ($urandom_range(0, 3) == 0);
			rx_busy = ($urandom_range(0, 3) == 0);
			n_valid = 0;
			while (n_valid < PHASE_ITEMS) begin
				case ($urandom_range(0, 7))
					0: tin = TIME_MAX - TIME_W'($urandom_range(0, 140000));
					1: tin = TIME_MIN + TIME_W'($urandom_range(0, 140000));
					default: tin = TIME_W'($urandom);
				endcase
				for (int s = 0; s < 2; s++) begin
					case ($urandom_range(0, 5))
						0: qv[s] = 12'd0;
						1: qv[s] = 12'd4095;
						2: qv[s] = CHARGE_W'($urandom_range(0, 255));
						default: qv[s] = CHARGE_W'($urandom);
					endcase
				end
				cv = ($urandom_range(0, 9) != 0);
				if (cv) n_valid++;
				send_item(tin, qv[0], qv[1], cv, 0, typed);
			end
		end
		tx_busy = 0;
		rx_busy = 0;
		in_valid = 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (FLUSH_WAIT * 2) @(posedge clk);
		if (err_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== tof_slew_correction_core.f =====
+incdir+hw/rtl
hw/rtl/tsc_pkg.sv
hw/rtl/tsc_slew_term.sv
hw/rtl/tof_slew_correction_core.sv
test/tb_tof_slew_correction_core.sv
